[hdl/ljsr_pkg.sv]
// ---------------------------------------------------------------------------
// ljsr_pkg: shared types, codes and tables for the lossless-JPEG slice
// reconstructor (predictor 1, slice unscrambling)
// ---------------------------------------------------------------------------
package ljsr_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int COORD_BITS  = 16;

   localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);
   localparam logic [15:0] COORD_MASK  = 16'((32'd1 << COORD_BITS) - 32'd1);

   // register indexes
   localparam logic [2:0] CSR_MODE             = 3'd0;
   localparam logic [2:0] CSR_INITIAL_PRED     = 3'd1;
   localparam logic [2:0] CSR_ROW_PIXELS       = 3'd2;
   localparam logic [2:0] CSR_SLICE_WIDTH      = 3'd3;
   localparam logic [2:0] CSR_LAST_SLICE_WIDTH = 3'd4;
   localparam logic [2:0] CSR_SLICE_COUNT      = 3'd5;
   localparam logic [2:0] CSR_SLICE_ROWS       = 3'd6;
   localparam logic [2:0] CSR_IMAGE_ROWS       = 3'd7;

   // component layouts
   localparam logic [1:0] MODE_TWO  = 2'd0;
   localparam logic [1:0] MODE_FOUR = 2'd1;
   localparam logic [1:0] MODE_Y2X1 = 2'd2;
   localparam logic [1:0] MODE_Y2X2 = 2'd3;

   localparam logic [15:0] INIT_PRED_RESET = 16'h8000 & SAMPLE_MASK;

   typedef struct packed {
      logic        [1:0]  mode;
      logic        [15:0] initial_predictor;
      logic        [15:0] row_pixels;
      logic        [15:0] slice_width;
      logic        [15:0] last_slice_width;
      logic        [7:0]  slice_count;
      logic        [15:0] slice_rows;
      logic        [15:0] image_rows;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] difference;
      logic               start_of_scan;
   } req_type;

   typedef struct packed {
      logic [15:0] sample_value;
      logic [15:0] dest_column;
      logic [15:0] dest_row;
      logic [1:0]  component;
   } rsp_type;

   // position tracker to reconstruction datapath
   typedef struct packed {
      logic [3:0] reload_mask;
      logic       capture;
      logic [1:0] comp;
   } ctl_type;

   function automatic logic [15:0] at_least_one(input logic [15:0] v);
      at_least_one = (v == 16'd0) ? 16'd1 : v;
   endfunction

   function automatic logic [2:0] grp_size(input logic [1:0] m);
      case (m)
         MODE_TWO:  grp_size = 3'd2;
         MODE_FOUR: grp_size = 3'd4;
         MODE_Y2X1: grp_size = 3'd4;
         default:   grp_size = 3'd6;
      endcase
   endfunction

   function automatic logic [2:0] x_step(input logic [1:0] m);
      case (m)
         MODE_TWO:  x_step = 3'd2;
         MODE_FOUR: x_step = 3'd4;
         default:   x_step = 3'd6;
      endcase
   endfunction

   function automatic logic [1:0] y_step(input logic [1:0] m);
      y_step = (m == MODE_Y2X2) ? 2'd2 : 2'd1;
   endfunction

   function automatic logic [1:0] px_inc(input logic [1:0] m);
      px_inc = (m == MODE_Y2X1 || m == MODE_Y2X2) ? 2'd2 : 2'd1;
   endfunction

   function automatic logic [3:0] reload_mask(input logic [1:0] m);
      case (m)
         MODE_TWO:  reload_mask = 4'b0011;
         MODE_FOUR: reload_mask = 4'b1111;
         default:   reload_mask = 4'b0111;
      endcase
   endfunction

   function automatic logic [1:0] comp_of(input logic [1:0] m, input logic [2:0] pos);
      comp_of = 2'd0;
      case (m)
         MODE_TWO:  comp_of = (pos == 3'd1) ? 2'd1 : 2'd0;
         MODE_FOUR: comp_of = pos[1:0];
         MODE_Y2X1: begin
            case (pos)
               3'd2:    comp_of = 2'd1;
               3'd3:    comp_of = 2'd2;
               default: comp_of = 2'd0;
            endcase
         end
         default: begin
            case (pos)
               3'd4:    comp_of = 2'd1;
               3'd5:    comp_of = 2'd2;
               default: comp_of = 2'd0;
            endcase
         end
      endcase
   endfunction

   function automatic logic [1:0] col_of(input logic [1:0] m, input logic [2:0] pos);
      col_of = 2'd0;
      case (m)
         MODE_TWO:  col_of = (pos == 3'd1) ? 2'd1 : 2'd0;
         MODE_FOUR: col_of = pos[1:0];
         MODE_Y2X1: begin
            case (pos)
               3'd1:    col_of = 2'd3;
               3'd2:    col_of = 2'd1;
               3'd3:    col_of = 2'd2;
               default: col_of = 2'd0;
            endcase
         end
         default: begin
            case (pos)
               3'd1, 3'd3: col_of = 2'd3;
               3'd4:       col_of = 2'd1;
               3'd5:       col_of = 2'd2;
               default:    col_of = 2'd0;
            endcase
         end
      endcase
   endfunction

   function automatic logic row_of(input logic [1:0] m, input logic [2:0] pos);
      row_of = (m == MODE_Y2X2) && (pos == 3'd2 || pos == 3'd3);
   endfunction

endpackage

[hdl/ljsr_csr.sv]
// ---------------------------------------------------------------------------
// ljsr_csr: configuration register file
// Holds the eight scan and slice geometry registers, written one per beat.
// ---------------------------------------------------------------------------
module ljsr_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_data,
   output ljsr_pkg::cfg_type cfg
);

   ljsr_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            ljsr_pkg::CSR_MODE:             cfg_in.mode              = csr_data[1:0];
            ljsr_pkg::CSR_INITIAL_PRED:     cfg_in.initial_predictor = csr_data;
            ljsr_pkg::CSR_ROW_PIXELS:       cfg_in.row_pixels        = csr_data;
            ljsr_pkg::CSR_SLICE_WIDTH:      cfg_in.slice_width       = csr_data;
            ljsr_pkg::CSR_LAST_SLICE_WIDTH: cfg_in.last_slice_width  = csr_data;
            ljsr_pkg::CSR_SLICE_COUNT:      cfg_in.slice_count       = csr_data[7:0];
            ljsr_pkg::CSR_SLICE_ROWS:       cfg_in.slice_rows        = csr_data;
            ljsr_pkg::CSR_IMAGE_ROWS:       cfg_in.image_rows        = csr_data;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode              <= ljsr_pkg::MODE_TWO;
         cfg_ff.initial_predictor <= 16'h8000;
         cfg_ff.row_pixels        <= 16'd1;
         cfg_ff.slice_width       <= 16'd1;
         cfg_ff.last_slice_width  <= 16'd1;
         cfg_ff.slice_count       <= 8'd0;
         cfg_ff.slice_rows        <= 16'd1;
         cfg_ff.image_rows        <= 16'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hdl/ljsr_track.sv]
// ---------------------------------------------------------------------------
// ljsr_track: group position and destination address tracker
// Walks the group, counts pixels for predictor reload, and steps the
// slice column, slice line, destination row and column base.
// ---------------------------------------------------------------------------
module ljsr_track (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic              sos,
   input  ljsr_pkg::cfg_type cfg,
   output ljsr_pkg::ctl_type ctl,
   output logic [15:0]       dest_column,
   output logic [15:0]       dest_row
);

   logic [15:0] pix_ff, pix_in;
   logic [2:0]  gpos_ff, gpos_in;
   logic        cap_ff, cap_in;
   logic [15:0] col_ff, col_in;
   logic [15:0] row_ff, row_in;
   logic [7:0]  sidx_ff, sidx_in;
   logic [15:0] drc_ff, drc_in;
   logic [15:0] base_ff, base_in;

   logic [15:0] eff_pix, eff_col, eff_row, eff_drc, eff_base;
   logic [2:0]  eff_gpos, gsize, gp0, gp_nx;
   logic [7:0]  eff_sidx;
   logic        eff_cap, reload, cap_a, end_grp;
   logic [15:0] pix_a;
   logic [1:0]  comp, xoff, ystep;
   logic        yoff;
   logic [15:0] width, rows, step;
   logic [16:0] col_sum, drc1, drc2, drc3, rsl;
   logic        wrap_col, sub1, sub2, wrap_row;
   logic [15:0] base_nx;

   always_comb begin
      // scan start clears position before this beat is handled
      eff_pix  = sos ? 16'd0 : pix_ff;
      eff_gpos = sos ? 3'd0  : gpos_ff;
      eff_cap  = sos | cap_ff;
      eff_col  = sos ? 16'd0 : col_ff;
      eff_row  = sos ? 16'd0 : row_ff;
      eff_sidx = sos ? 8'd0  : sidx_ff;
      eff_drc  = sos ? 16'd0 : drc_ff;
      eff_base = sos ? 16'd0 : base_ff;

      gsize  = ljsr_pkg::grp_size(cfg.mode);
      gp0    = (eff_gpos >= gsize) ? 3'd0 : eff_gpos;
      reload = (gp0 == 3'd0) && (eff_pix == ljsr_pkg::at_least_one(cfg.row_pixels));
      pix_a  = reload ? 16'd0 : eff_pix;
      cap_a  = reload | eff_cap;

      comp = ljsr_pkg::comp_of(cfg.mode, gp0);
      xoff = ljsr_pkg::col_of(cfg.mode, gp0);
      yoff = ljsr_pkg::row_of(cfg.mode, gp0);

      ctl.reload_mask = reload ? ljsr_pkg::reload_mask(cfg.mode) : 4'b0000;
      ctl.capture     = cap_a && (xoff == comp) && !yoff;
      ctl.comp        = comp;

      dest_column = (eff_base + eff_col + 16'(xoff)) & ljsr_pkg::COORD_MASK;
      dest_row    = (eff_drc + 16'(yoff)) & ljsr_pkg::COORD_MASK;

      gp_nx   = gp0 + 3'd1;
      end_grp = gp_nx >= gsize;

      width    = ljsr_pkg::at_least_one((eff_sidx < cfg.slice_count) ?
                                        cfg.slice_width : cfg.last_slice_width);
      col_sum  = {1'b0, eff_col} + 17'(ljsr_pkg::x_step(cfg.mode));
      wrap_col = col_sum >= {1'b0, width};

      // destination row wraps at most twice per line step
      ystep = ljsr_pkg::y_step(cfg.mode);
      rows  = ljsr_pkg::at_least_one(cfg.image_rows);
      step  = ljsr_pkg::at_least_one((cfg.slice_count == 8'd0) ?
                                     cfg.last_slice_width : cfg.slice_width);
      drc1  = {1'b0, eff_drc} + 17'(ystep);
      sub1  = drc1 >= {1'b0, rows};
      drc2  = sub1 ? (drc1 - {1'b0, rows}) : drc1;
      sub2  = drc2 >= {1'b0, rows};
      drc3  = sub2 ? (drc2 - {1'b0, rows}) : drc2;
      base_nx = eff_base + (sub1 ? step : 16'd0) + (sub2 ? step : 16'd0);

      rsl      = {1'b0, eff_row} + 17'(ystep);
      wrap_row = rsl >= {1'b0, ljsr_pkg::at_least_one(cfg.slice_rows)};

      pix_in  = pix_ff;
      gpos_in = gpos_ff;
      cap_in  = cap_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      sidx_in = sidx_ff;
      drc_in  = drc_ff;
      base_in = base_ff;

      if (fire) begin
         col_in  = eff_col;
         row_in  = eff_row;
         sidx_in = eff_sidx;
         drc_in  = eff_drc;
         base_in = eff_base;
         if (end_grp) begin
            gpos_in = 3'd0;
            cap_in  = 1'b0;
            pix_in  = pix_a + 16'(ljsr_pkg::px_inc(cfg.mode));
            if (wrap_col) begin
               col_in  = 16'd0;
               drc_in  = drc3[15:0];
               base_in = base_nx;
               if (wrap_row) begin
                  row_in = 16'd0;
                  if (eff_sidx < cfg.slice_count) begin
                     sidx_in = eff_sidx + 8'd1;
                  end
               end else begin
                  row_in = rsl[15:0];
               end
            end else begin
               col_in = col_sum[15:0];
            end
         end else begin
            gpos_in = gp_nx;
            cap_in  = cap_a;
            pix_in  = pix_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff  <= 16'd0;
         gpos_ff <= 3'd0;
         cap_ff  <= 1'b1;
         col_ff  <= 16'd0;
         row_ff  <= 16'd0;
         sidx_ff <= 8'd0;
         drc_ff  <= 16'd0;
         base_ff <= 16'd0;
      end else begin
         pix_ff  <= pix_in;
         gpos_ff <= gpos_in;
         cap_ff  <= cap_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         sidx_ff <= sidx_in;
         drc_ff  <= drc_in;
         base_ff <= base_in;
      end
   end

endmodule

[hdl/ljsr_recon.sv]
// ---------------------------------------------------------------------------
// ljsr_recon: predictor-1 sample reconstruction
// Four component predictors, the row start copies they reload from, and
// the modular add of predictor and difference.
// ---------------------------------------------------------------------------
module ljsr_recon (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic               sos,
   input  logic signed [15:0] difference,
   input  logic [15:0]        initial_predictor,
   input  ljsr_pkg::ctl_type  ctl,
   output logic [15:0]        sample_value
);

   logic [15:0] pred_ff [4];
   logic [15:0] pred_in [4];
   logic [15:0] rsv_ff  [4];
   logic [15:0] rsv_in  [4];
   logic [15:0] pred_rl [4];
   logic [15:0] val;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         pred_rl[i] = sos ? (initial_predictor & ljsr_pkg::SAMPLE_MASK) : pred_ff[i];
         if (ctl.reload_mask[i]) begin
            pred_rl[i] = rsv_ff[i];
         end
      end

      val = (pred_rl[ctl.comp] + unsigned'(difference)) & ljsr_pkg::SAMPLE_MASK;

      for (int i = 0; i < 4; i++) begin
         pred_in[i] = pred_ff[i];
         rsv_in[i]  = rsv_ff[i];
         if (fire) begin
            pred_in[i] = (ctl.comp == 2'(i)) ? val : pred_rl[i];
            // first group after a reload refreshes the row start copy
            if (ctl.capture && ctl.comp == 2'(i)) begin
               rsv_in[i] = val;
            end
         end
      end
   end

   assign sample_value = val;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            pred_ff[i] <= ljsr_pkg::INIT_PRED_RESET;
         end
      end else begin
         for (int i = 0; i < 4; i++) begin
            pred_ff[i] <= pred_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         rsv_ff[i] <= rsv_in[i];
      end
   end

endmodule

[hdl/lossless_jpeg_slice_reconstructor.sv]
// ---------------------------------------------------------------------------
// lossless_jpeg_slice_reconstructor: predictor-1 lossless-JPEG sample
// rebuild with slice unscrambling
// Adds each decoded difference to its component predictor and tags the
// sample with its destination column and row.
//
//   channel  direction  handshake            beat
//   req_     in         req_valid/req_stall  difference, start_of_scan
//   rsp_     out        rsp_valid/rsp_stall  sample, column, row, component
//   csr_     in         csr_valid/csr_ready  register index, write data
//
// One beat per cycle sustained while rsp_stall stays low; a taken req beat
// is held in the input register, and its result in the result register,
// which drives rsp_valid. The rate is set by the predictor add and position
// update loop between the input register and the result register.
// Synchronous reset empties both registers and restores the scan state.
// rsp_stall holds the result register; req_stall rises only while both
// the input and result registers are full and the result is stalled.
// ---------------------------------------------------------------------------
module lossless_jpeg_slice_reconstructor (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ljsr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ljsr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_data
);

   ljsr_pkg::cfg_type cfg;
   ljsr_pkg::ctl_type ctl;

   logic              s1_valid_ff, s1_valid_in;
   ljsr_pkg::req_type s1_data_ff, s1_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ljsr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic        out_free, fire, accept;
   logic [15:0] sample_value, dest_column, dest_row;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   ljsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ljsr_track u_track (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .sos         (s1_data_ff.start_of_scan),
      .cfg         (cfg),
      .ctl         (ctl),
      .dest_column (dest_column),
      .dest_row    (dest_row)
   );

   ljsr_recon u_recon (
      .clock             (clock),
      .reset             (reset),
      .fire              (fire),
      .sos               (s1_data_ff.start_of_scan),
      .difference        (s1_data_ff.difference),
      .initial_predictor (cfg.initial_predictor),
      .ctl               (ctl),
      .sample_value      (sample_value)
   );

   always_comb begin
      s1_valid_in  = accept | (s1_valid_ff & !fire);
      s1_data_in   = accept ? req_data : s1_data_ff;
      rsp_valid_in = fire | (rsp_valid_ff & rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_data_in.sample_value = sample_value;
         rsp_data_in.dest_column  = dest_column;
         rsp_data_in.dest_row     = dest_row;
         rsp_data_in.component    = ctl.comp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hdl/ljsr_checker.sv]
// ---------------------------------------------------------------------------
// ljsr_checker: port-level checks for the slice reconstructor
// Watches the top-level ports only; attached by bind.
// ---------------------------------------------------------------------------
module ljsr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input ljsr_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ljsr_pkg::rsp_type rsp_data,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic [2:0]        csr_index,
   input logic [15:0]       csr_data
);

   // a stalled result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // input backs up only behind a stalled, full result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without a stalled result");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("config write refused");

   // a free result side never leaves an item waiting in front
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("req stalled while result side is free");

endmodule

bind lossless_jpeg_slice_reconstructor ljsr_checker u_ljsr_checker (.*);

[verif/tb_lossless_jpeg_slice_reconstructor.sv]
// ---------------------------------------------------------------------------
// tb_lossless_jpeg_slice_reconstructor: self-checking bench for the
// predictor-1 sample rebuild and slice unscrambling block
// A short table of hand-picked beats and register writes runs first,
// then random phases with new register settings each time. A local
// predictor tracks component predictors, row reloads and slice addressing.
// Every result beat is compared field by field, in order, with the
// predicted or tabled sample. Both sides stall in random bursts, and
// once the result side holds off long enough to back the block up.
// ---------------------------------------------------------------------------
module tb_lossless_jpeg_slice_reconstructor;

   localparam int unsigned RAND_PHASES    = 16;
   localparam int unsigned CALM_PHASES    = 2;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned PRESSURE_HOLD  = 60;

   // group layout per mode
   localparam int unsigned GRP_LEN   [4] = '{2, 4, 4, 6};
   localparam int unsigned COL_STEP  [4] = '{2, 4, 6, 6};
   localparam int unsigned LINE_STEP [4] = '{1, 1, 1, 2};
   localparam int unsigned PIX_STEP  [4] = '{1, 1, 2, 2};
   localparam int unsigned COMP_CNT  [4] = '{2, 4, 3, 3};
   localparam int unsigned COMP_AT [4][6] = '{'{0, 1, 0, 0, 0, 0}, '{0, 1, 2, 3, 0, 0},
                                              '{0, 0, 1, 2, 0, 0}, '{0, 0, 0, 0, 1, 2}};
   localparam int unsigned COL_AT  [4][6] = '{'{0, 1, 0, 0, 0, 0}, '{0, 1, 2, 3, 0, 0},
                                              '{0, 3, 1, 2, 0, 0}, '{0, 3, 0, 3, 1, 2}};
   localparam int unsigned ROW_AT  [4][6] = '{'{0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0},
                                              '{0, 0, 0, 0, 0, 0}, '{0, 0, 1, 1, 0, 0}};

   localparam logic [15:0] DIFF_EDGES [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

   typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [2:0]        idx;
      logic [15:0]       val;
      logic              sos;
      logic              typed;
      ljsr_pkg::rsp_type want;
   } dir_row_type;

   localparam int unsigned DIR_ROWS = 43;
   localparam dir_row_type DIR_TAB [DIR_ROWS] = '{
      // reset settings: two components, predictor 0x8000, every size one
      '{ROW_BEAT,  '0, 16'h0000, 1'b0, 1'b1, '{16'h8000, 16'd0, 16'd0, 2'd0}},
      '{ROW_BEAT,  '0, 16'h0001, 1'b0, 1'b1, '{16'h8001, 16'd1, 16'd0, 2'd1}},
      '{ROW_BEAT,  '0, 16'hFFFF, 1'b0, 1'b1, '{16'h7FFF, 16'd1, 16'd0, 2'd0}},
      '{ROW_BEAT,  '0, 16'h7FFF, 1'b0, 1'b1, '{16'h0000, 16'd2, 16'd0, 2'd1}},
      '{ROW_BEAT,  '0, 16'h8000, 1'b0, 1'b1, '{16'hFFFF, 16'd2, 16'd0, 2'd0}},
      '{ROW_BEAT,  '0, 16'h8000, 1'b1, 1'b1, '{16'h0000, 16'd0, 16'd0, 2'd0}},
      '{ROW_BEAT,  '0, 16'h7FFF, 1'b0, 1'b1, '{16'hFFFF, 16'd1, 16'd0, 2'd1}},
      // four components, small slices
      '{ROW_WRITE, ljsr_pkg::CSR_MODE, 16'(ljsr_pkg::MODE_FOUR), 1'b0, 1'b0, '0},
      '{ROW_WRITE, ljsr_pkg::CSR_INITIAL_PRED,     16'h0000, 1'b0, 1'b0, '0},
      '{ROW_WRITE, ljsr_pkg::CSR_ROW_PIXELS,       16'd3,    1'b0, 1'b0, '0},
      '{ROW_WRITE, ljsr_pkg::CSR_SLICE_WIDTH,      16'd8,    1'b0, 1'b0, '0},
      '{ROW_WRITE, ljsr_pkg::CSR_LAST_SLICE_WIDTH, 16'd4,    1'b0, 1'b0, '0},
      '{ROW_WRITE, ljsr_pkg::CSR_SLICE_COUNT,      16'd2,    1'b0, 1'b0, '0},
      '{ROW_WRITE, ljsr_pkg::CSR_SLICE_ROWS,       16'd2,    1'b0, 1'b0, '0},
      '{ROW_WRITE, ljsr_pkg::CSR_IMAGE_ROWS,       16'd3,    1'b0, 1'b0, '0},
      '{ROW_BEAT,  '0, 16'h0005, 1'b1, 1'b0, '0},
      '{ROW_BEAT,  '0, 16'hFFF0, 1'b0, 1'b0, '0},
      '{ROW_BEAT,  '0, 16'h1234, 1'b0, 1'b0, '0},
      '{ROW_BEAT,  '0, 16'h8000, 1'b0, 1'b0, '0},
      '{ROW_BEAT,  '0, 16'h0001, 1'b0, 1'b0, '0},
      '{ROW_BEAT,  '0, 16'h0002, 1'b0, 1'b0, '0},
      '{ROW_BEAT,  '0, 16'h7FFF, 1'b0, 1'b0, '0},
      // mode change with the group three beats in
      '{ROW_WRITE, ljsr_pkg::CSR_MODE, 16'(ljsr_pkg::MODE_TWO), 1'b0, 1'b0, '0},
      '{ROW_BEAT,  '0, 16'h0003, 1'b0, 1'b0, '0},
      '{ROW_BEAT,  '0, 16'hFFFE, 1'b0, 1'b0, '0},
      // 2x1 luma with an odd reload count, so no reload
      '{ROW_WRITE, ljsr_pkg::CSR_MODE, 16'(ljsr_pkg::MODE_Y2X1), 1'b0, 1'b0, '0},
      '{ROW_WRITE, ljsr_pkg::CSR_INITIAL_PRED,     16'hFFFF, 1'b0, 1'b0, '0},
      '{ROW_BEAT,  '0, 16'h0001, 1'b1, 1'b0, '0},
      '{ROW_BEAT,  '0, 16'h0002, 1'b0, 1'b0, '0},
      '{ROW_BEAT,  '0, 16'h0003, 1'b0, 1'b0, '0},
      '{ROW_BEAT,  '0, 16'h0004, 1'b0, 1'b0, '0},
      // 2x2 luma, zero sizes act as one, slice index pinned on the last slice
      '{ROW_WRITE, ljsr_pkg::CSR_MODE, 16'(ljsr_pkg::MODE_Y2X2), 1'b0, 1'b0, '0},
      '{ROW_WRITE, ljsr_pkg::CSR_ROW_PIXELS,       16'd0,    1'b0, 1'b0, '0},
      '{ROW_WRITE, ljsr_pkg::CSR_SLICE_WIDTH,      16'd0,    1'b0, 1'b0, '0},
      '{ROW_WRITE, ljsr_pkg::CSR_LAST_SLICE_WIDTH, 16'd0,    1'b0, 1'b0, '0},
      '{ROW_WRITE, ljsr_pkg::CSR_SLICE_COUNT,      16'd0,    1'b0, 1'b0, '0},
      '{ROW_WRITE, ljsr_pkg::CSR_SLICE_ROWS,       16'd0,    1'b0, 1'b0, '0},
      '{ROW_WRITE, ljsr_pkg::CSR_IMAGE_ROWS,       16'd0,    1'b0, 1'b0, '0},
      '{ROW_BEAT,  '0, 16'h8000, 1'b1, 1'b0, '0},
      '{ROW_BEAT,  '0, 16'h7FFF, 1'b0, 1'b0, '0},
      '{ROW_BEAT,  '0, 16'h0010, 1'b0, 1'b0, '0},
      '{ROW_BEAT,  '0, 16'hFFF0, 1'b0, 1'b0, '0},
      '{ROW_BEAT,  '0, 16'h0000, 1'b0, 1'b0, '0}
   };

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   ljsr_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   ljsr_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [2:0]        csr_index;
   logic [15:0]       csr_data;

   // predictor state and register copy
   ljsr_pkg::cfg_type shadow;
   logic [15:0] pred [4];
   logic [15:0] row_start [4];
   bit   [3:0]  row_start_seen;
   bit          capture;
   int unsigned pix_cnt, grp_pos, col_in_slice, row_in_slice;
   int unsigned slice_idx, dest_row, col_base;

   ljsr_pkg::rsp_type sample_q [$];
   int unsigned errors;
   int unsigned idle_rate;
   bit          pressure_go;

   lossless_jpeg_slice_reconstructor u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   function automatic int unsigned floor_one(logic [15:0] v);
      return (v == 16'd0) ? 1 : int'(v);
   endfunction

   function automatic void restart_scan();
      for (int i = 0; i < 4; i++) begin
         pred[i] = shadow.initial_predictor;
      end
      pix_cnt      = 0;
      grp_pos      = 0;
      col_in_slice = 0;
      row_in_slice = 0;
      slice_idx    = 0;
      dest_row     = 0;
      col_base     = 0;
      capture      = 1'b1;
   endfunction

   // true when the next beat would reload a predictor from a row start never captured
   function automatic bit reload_hits_unset(bit sos);
      int unsigned m, g;
      m = shadow.mode;
      g = (grp_pos >= GRP_LEN[m]) ? 0 : grp_pos;
      if (sos || g != 0 || pix_cnt != floor_one(shadow.row_pixels)) begin
         return 1'b0;
      end
      for (int i = 0; i < COMP_CNT[m]; i++) begin
         if (!row_start_seen[i]) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic ljsr_pkg::rsp_type reconstruct_sample(logic [15:0] diff, bit sos);
      int unsigned       m, pos, c, width, rows, step;
      ljsr_pkg::rsp_type r;
      m = shadow.mode;
      if (sos) begin
         restart_scan();
      end
      if (grp_pos >= GRP_LEN[m]) begin
         grp_pos = 0;
      end
      if (grp_pos == 0 && pix_cnt == floor_one(shadow.row_pixels)) begin
         for (int i = 0; i < COMP_CNT[m]; i++) begin
            pred[i] = row_start[i];
         end
         capture = 1'b1;
         pix_cnt = 0;
      end
      pos     = grp_pos;
      c       = COMP_AT[m][pos];
      pred[c] = pred[c] + diff;
      if (capture && COL_AT[m][pos] == c && ROW_AT[m][pos] == 0) begin
         row_start[c]      = pred[c];
         row_start_seen[c] = 1'b1;
      end
      r.sample_value = pred[c];
      r.dest_column  = 16'(col_base + col_in_slice + COL_AT[m][pos]);
      r.dest_row     = 16'(dest_row + ROW_AT[m][pos]);
      r.component    = 2'(c);

      grp_pos = pos + 1;
      if (grp_pos >= GRP_LEN[m]) begin
         width   = floor_one(slice_idx < shadow.slice_count ? shadow.slice_width
                                                            : shadow.last_slice_width);
         grp_pos = 0;
         capture = 1'b0;
         pix_cnt = (pix_cnt + PIX_STEP[m]) & 32'hFFFF;
         col_in_slice += COL_STEP[m];
         if (col_in_slice >= width) begin
            col_in_slice = 0;
            rows = floor_one(shadow.image_rows);
            step = floor_one(shadow.slice_count == 0 ? shadow.last_slice_width
                                                     : shadow.slice_width);
            dest_row += LINE_STEP[m];
            // a two-row step can wrap twice on a one-row image
            repeat (2) begin
               if (dest_row >= rows) begin
                  dest_row -= rows;
                  col_base  = (col_base + step) & 32'hFFFF;
               end
            end
            row_in_slice += LINE_STEP[m];
            if (row_in_slice >= floor_one(shadow.slice_rows)) begin
               row_in_slice = 0;
               if (slice_idx < shadow.slice_count) begin
                  slice_idx++;
               end
            end
         end
      end
      return r;
   endfunction

   function automatic void field_check(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   function automatic logic [15:0] pick_dim(int unsigned hi);
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(1, hi));
      endcase
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      req_valid <= 1'b0;
      while (sample_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         ljsr_pkg::CSR_MODE:             shadow.mode              = val[1:0];
         ljsr_pkg::CSR_INITIAL_PRED:     shadow.initial_predictor = val;
         ljsr_pkg::CSR_ROW_PIXELS:       shadow.row_pixels        = val;
         ljsr_pkg::CSR_SLICE_WIDTH:      shadow.slice_width       = val;
         ljsr_pkg::CSR_LAST_SLICE_WIDTH: shadow.last_slice_width  = val;
         ljsr_pkg::CSR_SLICE_COUNT:      shadow.slice_count       = val[7:0];
         ljsr_pkg::CSR_SLICE_ROWS:       shadow.slice_rows        = val;
         ljsr_pkg::CSR_IMAGE_ROWS:       shadow.image_rows        = val;
         default: ;
      endcase
   endtask

   task automatic send_beat(logic [15:0] diff, bit sos, bit typed,
                            ljsr_pkg::rsp_type typed_want);
      ljsr_pkg::rsp_type want;
      // never let a reload read a row start this run has not written
      if (reload_hits_unset(sos)) begin
         sos = 1'b1;
      end
      want = reconstruct_sample(diff, sos);
      sample_q.insert(sample_q.size(), typed ? typed_want : want);
      if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{difference: diff, start_of_scan: sos};
      do @(posedge clock); while (req_stall);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side: checks each beat and drives stall
   initial begin : result_side
      int unsigned       hold_left, stall_left;
      bit                pressure_done;
      ljsr_pkg::rsp_type want;
      hold_left     = 0;
      stall_left    = 0;
      pressure_done = 1'b0;
      rsp_stall     = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (sample_q.size() == 0) begin
               $display("%0t: result beat with nothing expected, actual %h", $time, rsp_data);
               errors++;
            end else begin
               want = sample_q.pop_front();
               field_check("sample_value", want.sample_value, rsp_data.sample_value);
               field_check("dest_column", want.dest_column, rsp_data.dest_column);
               field_check("dest_row", want.dest_row, rsp_data.dest_row);
               field_check("component", 16'(want.component), 16'(rsp_data.component));
            end
         end
         if (pressure_go && !pressure_done) begin
            hold_left     = PRESSURE_HOLD;
            pressure_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
            stall_left = $urandom_range(1, 14) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ends the run if nothing moves on any channel for too long
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL lossless_jpeg_slice_reconstructor");
      $finish;
   end

   initial begin : stimulus
      logic [15:0] setting [8];
      logic [15:0] diff;
      bit          sos;
      int unsigned n_items;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_index   = ljsr_pkg::CSR_MODE;
      csr_data    = '0;
      reset       = 1'b1;
      errors      = 0;
      idle_rate   = 4;
      pressure_go = 1'b0;

      shadow.mode              = ljsr_pkg::MODE_TWO;
      shadow.initial_predictor = ljsr_pkg::INIT_PRED_RESET;
      shadow.row_pixels        = 16'd1;
      shadow.slice_width       = 16'd1;
      shadow.last_slice_width  = 16'd1;
      shadow.slice_count       = 8'd0;
      shadow.slice_rows        = 16'd1;
      shadow.image_rows        = 16'd1;
      row_start_seen           = '0;
      restart_scan();

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int k = 0; k < DIR_ROWS; k++) begin
         if (DIR_TAB[k].kind == ROW_WRITE) begin
            write_reg(DIR_TAB[k].idx, DIR_TAB[k].val);
         end else begin
            send_beat(DIR_TAB[k].val, DIR_TAB[k].sos, DIR_TAB[k].typed, DIR_TAB[k].want);
         end
      end

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         if (ph == 0) begin
            setting[ljsr_pkg::CSR_MODE]             = 16'(ljsr_pkg::MODE_Y2X2);
            setting[ljsr_pkg::CSR_INITIAL_PRED]     = 16'hFFFF;
            setting[ljsr_pkg::CSR_ROW_PIXELS]       = 16'hFFFF;
            setting[ljsr_pkg::CSR_SLICE_WIDTH]      = 16'hFFFF;
            setting[ljsr_pkg::CSR_LAST_SLICE_WIDTH] = 16'hFFFF;
            setting[ljsr_pkg::CSR_SLICE_COUNT]      = 16'd255;
            setting[ljsr_pkg::CSR_SLICE_ROWS]       = 16'hFFFF;
            setting[ljsr_pkg::CSR_IMAGE_ROWS]       = 16'hFFFF;
         end else if (ph == 1) begin
            setting[ljsr_pkg::CSR_MODE]             = 16'(ljsr_pkg::MODE_TWO);
            setting[ljsr_pkg::CSR_INITIAL_PRED]     = 16'h0000;
            setting[ljsr_pkg::CSR_ROW_PIXELS]       = 16'd0;
            setting[ljsr_pkg::CSR_SLICE_WIDTH]      = 16'd0;
            setting[ljsr_pkg::CSR_LAST_SLICE_WIDTH] = 16'd0;
            setting[ljsr_pkg::CSR_SLICE_COUNT]      = 16'd0;
            setting[ljsr_pkg::CSR_SLICE_ROWS]       = 16'd0;
            setting[ljsr_pkg::CSR_IMAGE_ROWS]       = 16'd0;
         end else begin
            setting[ljsr_pkg::CSR_MODE] = 16'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
               0:       setting[ljsr_pkg::CSR_INITIAL_PRED] = 16'h0000;
               1:       setting[ljsr_pkg::CSR_INITIAL_PRED] = 16'h8000;
               2:       setting[ljsr_pkg::CSR_INITIAL_PRED] = 16'hFFFF;
               default: setting[ljsr_pkg::CSR_INITIAL_PRED] = 16'($urandom);
            endcase
            setting[ljsr_pkg::CSR_ROW_PIXELS]       = pick_dim(10);
            setting[ljsr_pkg::CSR_SLICE_WIDTH]      = pick_dim(16);
            setting[ljsr_pkg::CSR_LAST_SLICE_WIDTH] = pick_dim(16);
            setting[ljsr_pkg::CSR_SLICE_COUNT]      =
               ($urandom_range(0, 9) == 0) ? 16'd255 : 16'($urandom_range(0, 3));
            setting[ljsr_pkg::CSR_SLICE_ROWS]       = pick_dim(4);
            setting[ljsr_pkg::CSR_IMAGE_ROWS]       = pick_dim(8);
         end
         for (int r = 0; r < 8; r++) begin
            write_reg(3'(r), setting[r]);
         end

         // long result hold-off once, sender keeps going so the block backs up
         if (ph == 2) begin
            idle_rate   = 0;
            pressure_go = 1'b1;
         end else if (ph >= RAND_PHASES - CALM_PHASES) begin
            idle_rate = 0;
         end else begin
            case ($urandom_range(0, 3))
               0:       idle_rate = 0;
               1:       idle_rate = 2;
               2:       idle_rate = 6;
               default: idle_rate = 15;
            endcase
         end

         n_items = $urandom_range(70, 120);
         for (int n = 0; n < n_items; n++) begin
            sos = (n == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 49) == 0);
            case ($urandom_range(0, 7))
               0:       diff = DIFF_EDGES[$urandom_range(0, 3)];
               1, 2, 3: diff = 16'($urandom_range(0, 32) - 16);
               default: diff = 16'($urandom);
            endcase
            send_beat(diff, sos, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (sample_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
      if (errors == 0) begin
         $display("PASS lossless_jpeg_slice_reconstructor");
      end else begin
         $display("FAIL lossless_jpeg_slice_reconstructor");
      end
      $finish;
   end

endmodule
